/* rtl/imussr_pkg.sv */
`timescale 1ns / 1ps

package imussr_pkg;

  localparam logic [15:0] MAG_RES_XY_DEF = 16'd19661;
  localparam logic [15:0] MAG_RES_Z_DEF  = 16'd9830;

  localparam logic [47:0] MAG_GAIN_RESET = 48'h1000_1000_1000;

  localparam logic [2:0] CFG_GEOMETRY   = 3'd0;
  localparam logic [2:0] CFG_ACCEL_SEL  = 3'd1;
  localparam logic [2:0] CFG_GYRO_SEL   = 3'd2;
  localparam logic [2:0] CFG_ACCEL_BIAS = 3'd3;
  localparam logic [2:0] CFG_GYRO_BIAS  = 3'd4;
  localparam logic [2:0] CFG_MAG_BIAS   = 3'd5;
  localparam logic [2:0] CFG_MAG_GAIN   = 3'd6;

  typedef enum logic [1:0] {
    OP_ACCEL = 2'd0,
    OP_GYRO  = 2'd1,
    OP_MAG   = 2'd2,
    OP_NONE  = 2'd3
  } imussr_op_e;

  typedef struct packed {
    logic       en1;
    logic       en2;
    imussr_op_e op0;
    imussr_op_e op1;
    imussr_op_e op2;
  } imussr_ctl_t;

  typedef struct packed {
    logic signed [11:0] acc;
    logic signed [15:0] gyro;
    logic signed [14:0] mag;
  } imussr_cnt_t;

  function automatic logic [12:0] gyro_scale(input logic [2:0] sel);
    logic [12:0] s;
    case (sel)
      3'd0:    s = 13'd4000;
      3'd1:    s = 13'd2000;
      3'd2:    s = 13'd1000;
      3'd3:    s = 13'd500;
      default: s = 13'd250;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [38:0] v);
    logic [31:0] r;
    if (!v[38] && (v[37:31] != 7'd0)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[38] && (v[37:31] != 7'h7F)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/imussr_lane.sv */
`timescale 1ns / 1ps

module imussr_lane
  import imussr_pkg::*;
(
  input  logic               clk_i,
  input  imussr_ctl_t        ctl_i,
  input  imussr_cnt_t        cnt_i,
  input  logic [1:0]         accel_sel_i,
  input  logic [2:0]         gyro_sel_i,
  input  logic [15:0]        mag_res_i,
  input  logic [15:0]        accel_bias_i,
  input  logic [15:0]        gyro_bias_i,
  input  logic [15:0]        mag_bias_i,
  input  logic [15:0]        mag_gain_i,
  output logic signed [37:0] val_o
);

  logic signed [13:0] gscale_s;
  logic signed [16:0] res_s;
  logic signed [16:0] gain_s;
  logic signed [29:0] gyro_prod;
  logic signed [31:0] mag_prod;
  logic signed [31:0] acc_ext;
  logic signed [31:0] prod1_d, prod1_q;
  logic signed [27:0] bias_term;
  logic signed [32:0] sub;
  logic signed [49:0] gain_prod;
  logic signed [49:0] val2_d, val2_q;
  logic signed [49:0] rnd;

  assign gscale_s  = $signed({1'b0, gyro_scale(gyro_sel_i)});
  assign res_s     = $signed({1'b0, mag_res_i});
  assign gain_s    = $signed({1'b0, mag_gain_i});
  assign gyro_prod = cnt_i.gyro * gscale_s;
  assign mag_prod  = cnt_i.mag * res_s;
  assign acc_ext   = 32'(cnt_i.acc);

  always_comb begin
    prod1_d = '0;
    case (ctl_i.op0)
      OP_ACCEL: prod1_d = acc_ext <<< ({2'b00, accel_sel_i} + 4'd6);
      OP_GYRO:  prod1_d = 32'(gyro_prod);
      OP_MAG:   prod1_d = mag_prod;
      default:  prod1_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      prod1_q <= prod1_d;
    end
  end

  always_comb begin
    bias_term = '0;
    case (ctl_i.op1)
      OP_ACCEL: bias_term = 28'($signed(accel_bias_i)) <<< 4;
      OP_GYRO:  bias_term = 28'($signed(gyro_bias_i)) <<< 12;
      OP_MAG:   bias_term = 28'($signed(mag_bias_i)) <<< 12;
      default:  bias_term = '0;
    endcase
  end

  assign sub       = 33'(prod1_q) - 33'(bias_term);
  assign gain_prod = sub * gain_s;
  assign val2_d    = (ctl_i.op1 == OP_MAG) ? gain_prod : 50'(sub);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      val2_q <= val2_d;
    end
  end

  assign rnd   = val2_q + 50'sd2048;
  assign val_o = (ctl_i.op2 == OP_MAG) ? rnd[49:12] : val2_q[37:0];

endmodule

/* rtl/imussr_remap.sv */
`timescale 1ns / 1ps

module imussr_remap
  import imussr_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  imussr_op_e         op_i,
  input  logic [2:0]         geometry_i,
  input  logic [15:0]        temp_i,
  input  logic signed [37:0] val_i [3],
  output logic [1:0]         sensor_id_o,
  output logic [31:0]        out_x_o,
  output logic [31:0]        out_y_o,
  output logic [31:0]        out_z_o,
  output logic [15:0]        temp_q8_o,
  output logic               temp_valid_o
);

  logic signed [38:0] pa, pb, pc, na, nb, nc;
  logic signed [38:0] rx, ry, rz;
  logic [31:0] x_q, y_q, z_q;
  logic [15:0] temp_q;
  logic [1:0]  id_q;
  logic        tv_q;

  assign pa = 39'(val_i[0]);
  assign pb = 39'(val_i[1]);
  assign pc = 39'(val_i[2]);
  assign na = -pa;
  assign nb = -pb;
  assign nc = -pc;

  always_comb begin
    rx = pa;
    ry = pb;
    rz = pc;
    unique case (geometry_i)
      3'd0: begin rx = pa; ry = pb; rz = pc; end
      3'd1: begin rx = nb; ry = pa; rz = pc; end
      3'd2: begin
        if (op_i == OP_MAG) begin
          rx = pa;
          ry = pb;
        end else begin
          rx = na;
          ry = nb;
        end
        rz = pc;
      end
      3'd3: begin rx = pb; ry = na; rz = pc; end
      3'd4: begin rx = nc; ry = nb; rz = na; end
      3'd5: begin rx = nc; ry = pa; rz = nb; end
      3'd6: begin rx = nc; ry = pb; rz = pa; end
      default: begin rx = nc; ry = na; rz = pb; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= sat32(rx);
      y_q    <= sat32(ry);
      z_q    <= sat32(rz);
      id_q   <= op_i;
      tv_q   <= (op_i == OP_ACCEL);
      temp_q <= (op_i == OP_ACCEL) ? temp_i : 16'd0;
    end
  end

  assign sensor_id_o  = id_q;
  assign out_x_o      = x_q;
  assign out_y_o      = y_q;
  assign out_z_o      = z_q;
  assign temp_q8_o    = temp_q;
  assign temp_valid_o = tv_q;

endmodule

/* rtl/imu_sample_scale_remap_unit.sv */
`timescale 1ns / 1ps

// Calibrates one raw accel, gyro or magnetometer frame per cycle: three axis lanes
// scale the counts, take off the bias and, for magnetometer frames, apply the
// soft-iron gain, then a merge stage remaps the axes for the mounting and saturates
// to Q16 in 32 bits. A frame passes from input request to output request through
// the count product, bias and gain product, and remap and saturation registers;
// each stage stalls only when the one after it is full, so a frame is taken every
// cycle while results are drained. Frames tagged with sensor code 3 are taken and
// dropped. Configuration writes must arrive only while no frame is in flight.
module imu_sample_scale_remap_unit
  import imussr_pkg::*;
#(
  parameter logic [15:0] MAG_RES_XY_Q16 = MAG_RES_XY_DEF,
  parameter logic [15:0] MAG_RES_Z_Q16  = MAG_RES_Z_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte,
  // temp_byte
  input  logic [55:0]  s_axis_tdata_i,
  // op
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_x, out_y, out_z, temp_q8
  output logic [111:0] m_axis_tdata_o,
  // sensor_id, temp_valid
  output logic [2:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [47:0]  cfg_data_i
);

  logic [2:0]  geometry_q;
  logic [1:0]  accel_sel_q;
  logic [2:0]  gyro_sel_q;
  logic [47:0] accel_bias_q, gyro_bias_q, mag_bias_q, mag_gain_q;

  logic        v1_q, v2_q, v3_q;
  logic        en1, en2, en3;
  imussr_op_e  op_in, op1_q, op2_q;
  logic [15:0] temp_calc, temp1_q, temp2_q;
  imussr_ctl_t ctl;
  logic signed [37:0] lane_val [3];
  logic [1:0]  sensor_id;
  logic [31:0] out_x, out_y, out_z;
  logic [15:0] temp_q8;
  logic        temp_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geometry_q   <= 3'd0;
      accel_sel_q  <= 2'd3;
      gyro_sel_q   <= 3'd0;
      accel_bias_q <= '0;
      gyro_bias_q  <= '0;
      mag_bias_q   <= '0;
      mag_gain_q   <= MAG_GAIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GEOMETRY:   geometry_q   <= cfg_data_i[2:0];
        CFG_ACCEL_SEL:  accel_sel_q  <= cfg_data_i[1:0];
        CFG_GYRO_SEL:   gyro_sel_q   <= cfg_data_i[2:0];
        CFG_ACCEL_BIAS: accel_bias_q <= cfg_data_i;
        CFG_GYRO_BIAS:  gyro_bias_q  <= cfg_data_i;
        CFG_MAG_BIAS:   mag_bias_q   <= cfg_data_i;
        CFG_MAG_GAIN:   mag_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  assign op_in     = imussr_op_e'(s_axis_tuser_i);
  assign temp_calc = {8'd0, s_axis_tdata_i[55:48]} * 16'd127 + 16'd5248;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i && (op_in != OP_NONE);
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q   <= op_in;
      temp1_q <= temp_calc;
    end
    if (en2) begin
      op2_q   <= op1_q;
      temp2_q <= temp1_q;
    end
  end

  assign ctl.en1 = en1;
  assign ctl.en2 = en2;
  assign ctl.op0 = op_in;
  assign ctl.op1 = op1_q;
  assign ctl.op2 = op2_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [7:0]  lo, hi;
    imussr_cnt_t cnt;
    logic [15:0] res;

    assign lo       = s_axis_tdata_i[16*i +: 8];
    assign hi       = s_axis_tdata_i[16*i+8 +: 8];
    assign cnt.acc  = $signed({hi, lo[7:4]});
    assign cnt.gyro = $signed({hi, lo});
    if (i == 2) begin : g_z
      assign cnt.mag = $signed({hi, lo[7:1]});
      assign res     = MAG_RES_Z_Q16;
    end else begin : g_xy
      assign cnt.mag = 15'($signed({hi, lo[7:3]}));
      assign res     = MAG_RES_XY_Q16;
    end

    imussr_lane u_lane (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .cnt_i        (cnt),
      .accel_sel_i  (accel_sel_q),
      .gyro_sel_i   (gyro_sel_q),
      .mag_res_i    (res),
      .accel_bias_i (accel_bias_q[16*i +: 16]),
      .gyro_bias_i  (gyro_bias_q[16*i +: 16]),
      .mag_bias_i   (mag_bias_q[16*i +: 16]),
      .mag_gain_i   (mag_gain_q[16*i +: 16]),
      .val_o        (lane_val[i])
    );
  end

  imussr_remap u_remap (
    .clk_i        (clk_i),
    .en_i         (en3),
    .op_i         (op2_q),
    .geometry_i   (geometry_q),
    .temp_i       (temp2_q),
    .val_i        (lane_val),
    .sensor_id_o  (sensor_id),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_z_o      (out_z),
    .temp_q8_o    (temp_q8),
    .temp_valid_o (temp_valid)
  );

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {temp_q8, out_z, out_y, out_x};
  assign m_axis_tuser_o  = {temp_valid, sensor_id};

endmodule
